// File: design/b4eg_pkg.sv
package b4eg_pkg;

  // Width of the value field on the input channel.
  localparam int B4EG_IN_W = 32;

  // Default number of significant input bits.
  localparam int B4EG_VALUE_BITS = 32;

  // The code is built from s = 3*v + 6, then the payload is a long division by 3.
  localparam int unsigned B4EG_BIAS = 6;
  localparam logic [2:0]  B4EG_DIVISOR = 3'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_PREFIX,
    ST_PAYLOAD
  } b4eg_state_t;

  // Commands from the sequencer to the shift-register datapath.
  typedef struct packed {
    logic load;
    logic norm_shift;
    logic pay_shift;
  } b4eg_ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic top_nz;
    logic qbit;
  } b4eg_sts_t;

endpackage

// File: design/b4eg_if.sv
// Input channel: one value per beat.
interface b4eg_in_if;
  import b4eg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [B4EG_IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// Result channel: one code bit per beat.
interface b4eg_out_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic last;

  modport source (output valid, output code_bit, output last, input ready);
  modport sink (input valid, input code_bit, input last, output ready);
endinterface

// File: design/b4eg_datapath.sv
module b4eg_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic [b4eg_pkg::B4EG_IN_W-1:0] value,
  input  b4eg_pkg::b4eg_ctl_t            ctl,
  output b4eg_pkg::b4eg_sts_t            sts
);
  import b4eg_pkg::*;

  // Significant input bits, and the even width that holds 3*v + 6.
  localparam int W   = (VALUE_BITS < B4EG_IN_W) ? VALUE_BITS : B4EG_IN_W;
  localparam int SW  = W + 2;
  localparam int SWE = SW + (SW % 2);

  logic [SWE-1:0] sreg_r, sreg_nxt;
  logic [1:0]     rem_r, rem_nxt;
  logic [SWE-1:0] v_ext;
  logic [1:0]     top;
  logic [2:0]     trial;
  logic           qbit;

  assign v_ext = SWE'(value[W-1:0]);
  assign top   = sreg_r[SWE-1 -: 2];

  // One step of the long division by three, MSB first.
  assign trial = {rem_r, sreg_r[SWE-1]};
  assign qbit  = (trial >= B4EG_DIVISOR);

  assign sts.top_nz = |top;
  assign sts.qbit   = qbit;

  // Load s, shift a base-4 digit per cycle while normalizing, a bit per payload beat.
  always_comb begin
    sreg_nxt = sreg_r;
    rem_nxt  = rem_r;
    if (ctl.load) begin
      sreg_nxt = v_ext + (v_ext << 1) + SWE'(B4EG_BIAS);
    end else if (ctl.norm_shift) begin
      sreg_nxt = sreg_r << 2;
      // Dropping 4^h from the leading digit leaves a remainder below three.
      if (|top) begin
        rem_nxt = top - 2'd1;
      end
    end else if (ctl.pay_shift) begin
      sreg_nxt = sreg_r << 1;
      rem_nxt  = qbit ? 2'(trial - B4EG_DIVISOR) : trial[1:0];
    end
  end

  always_ff @(posedge clk) begin
    sreg_r <= sreg_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// File: design/b4eg_ctrl.sv
module b4eg_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_code_bit,
  output logic                out_last,
  input  b4eg_pkg::b4eg_sts_t sts,
  output b4eg_pkg::b4eg_ctl_t ctl
);
  import b4eg_pkg::*;

  localparam int W   = (VALUE_BITS < B4EG_IN_W) ? VALUE_BITS : B4EG_IN_W;
  localparam int SW  = W + 2;
  localparam int SWE = SW + (SW % 2);
  localparam int ND  = SWE / 2;
  localparam int HW  = $clog2(ND);
  localparam int CW  = $clog2(SWE);

  b4eg_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0] hreg_r, hreg_nxt;
  logic          cnt_one;
  logic          out_fire;

  assign cnt_one  = (cnt_r == CW'(1));
  assign out_fire = out_valid && out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_NORM;
      ST_NORM:    if (sts.top_nz) state_nxt = ST_PREFIX;
      ST_PREFIX:  if (out_ready && cnt_one) state_nxt = ST_PAYLOAD;
      ST_PAYLOAD: if (out_ready && cnt_one) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_code_bit   = 1'b0;
    out_last       = 1'b0;
    ctl.load       = 1'b0;
    ctl.norm_shift = 1'b0;
    ctl.pay_shift  = 1'b0;
    cnt_nxt        = cnt_r;
    hreg_nxt       = hreg_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
        // The counter walks the base-4 digits from the top.
        if (in_valid) cnt_nxt = CW'(ND - 1);
      end
      ST_NORM: begin
        ctl.norm_shift = 1'b1;
        // The leading digit's index is the half length h.
        if (sts.top_nz) begin
          hreg_nxt = cnt_r[HW-1:0];
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_PREFIX: begin
        // Unary prefix: h-1 zeros, then a one.
        out_valid    = 1'b1;
        out_code_bit = cnt_one;
        if (out_ready) begin
          cnt_nxt = cnt_one ? CW'({hreg_r, 1'b0}) : cnt_r - CW'(1);
        end
      end
      ST_PAYLOAD: begin
        out_valid     = 1'b1;
        out_code_bit  = sts.qbit;
        out_last      = cnt_one;
        ctl.pay_shift = out_ready;
        if (out_ready) cnt_nxt = cnt_r - CW'(1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      hreg_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hreg_r  <= hreg_nxt;
    end
  end

`ifndef SYNTHESIS
  // Input is only taken when no code bit is pending.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a code bit is pending");

  // The final beat of a codeword frees the block for the next value.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |=> in_ready)
    else $error("block not idle after final code bit");

  // The bit counter never runs out before the final bit, in prefix or payload.
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !in_ready) |-> (cnt_r != '0))
    else $error("bit counter empty while emitting");

  // Normalizing always ends with a nonzero leading digit at h of one or more.
  a_h_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM && sts.top_nz) |-> (cnt_r != '0))
    else $error("leading digit found at index zero");
`endif

endmodule

// File: design/base4_exp_golomb_bit_encoder_unit.sv
// Base-4 exp-Golomb encoder, one code bit per output beat.
// Per value: accept, normalize from the top digit down, one base-4 digit shifted per cycle
// (ND = (VALUE_BITS+2 rounded even)/2 digits, 17 at 32 bits), then 3h output beats.
// A new value is taken only after the final code bit; out_ready can stall each beat.
// The code-bit shift register and the 2-bit division remainder give a bit per beat.
// Active-low synchronous reset returns the sequencer to idle; the datapath is not reset.
module base4_exp_golomb_bit_encoder_unit #(
  parameter int VALUE_BITS = b4eg_pkg::B4EG_VALUE_BITS
) (
  input logic      clk,
  input logic      rst_n,
  b4eg_in_if.sink  in_ch,
  b4eg_out_if.source out_ch
);
  import b4eg_pkg::*;

  b4eg_ctl_t ctl;
  b4eg_sts_t sts;

  // Shift register, leading-digit detect and divide-by-three step.
  b4eg_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk   (clk),
    .value (in_ch.value),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Sequencer for normalize, prefix and payload phases.
  b4eg_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_code_bit (out_ch.code_bit),
    .out_last     (out_ch.last),
    .sts          (sts),
    .ctl          (ctl)
  );

endmodule
